// ===== design/akv_pkg.sv =====
package akv_pkg;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int KEY_W    = 64;
    localparam int KLEN_W   = 4;
    localparam int POS_W    = 12;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 3;
    localparam int KEY_MAX  = 8;

    // Saturation point for byte positions and value lengths
    localparam logic [POS_W-1:0] POS_CAP = {POS_W{1'b1}};

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SEP = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BSL = 8'h5C;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_VALUE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_VALUE     = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

    // Scanner phases
    localparam logic [PHASE_W-1:0] PH_SEP      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MATCH    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_VALSTART = 3'd2;
    localparam logic [PHASE_W-1:0] PH_VALUE    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SKIP     = 3'd4;

    // One result from the scanner
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    offset;
        logic [POS_W-1:0]    length;
    } akv_result_t;

    // Configured key
    typedef struct packed {
        logic [KEY_W-1:0]  chars;
        logic [KLEN_W-1:0] length;
    } akv_key_t;

endpackage

// ===== design/akv_if.sv =====
// Character input channel
interface akv_char_if
    import akv_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// Result output channel
interface akv_result_if
    import akv_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    value_offset;
    logic [POS_W-1:0]    value_length;

    modport source (output valid, output status, output value_offset,
                    output value_length, input ready);
    modport sink   (input valid, input status, input value_offset,
                    input value_length, output ready);
endinterface

// Configuration write channel
interface akv_cfg_if
    import akv_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [KEY_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/akv_cfg_regs.sv =====
module akv_cfg_regs
    import akv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    akv_cfg_if.sink      cfg,
    output akv_key_t     key
);

    logic [KEY_W-1:0]  key_chars_reg;
    logic [KLEN_W-1:0] key_length_reg;

    // Writes are always taken
    assign cfg.ready = 1'b1;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= '0;
            key_length_reg <= KLEN_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_KEY_CHARS:  key_chars_reg  <= cfg.data;
                REG_KEY_LENGTH: key_length_reg <= cfg.data[KLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign key.chars  = key_chars_reg;
    assign key.length = key_length_reg;

endmodule

// ===== design/akv_scanner.sv =====
module akv_scanner
    import akv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] c,
    input  akv_key_t          key,
    output akv_result_t       result
);

    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [KLEN_W-1:0]  match_reg,   match_next;
    logic               bsl_reg,     bsl_next;
    logic [POS_W-1:0]   pos_reg,     pos_next;
    logic [POS_W-1:0]   vstart_reg,  vstart_next;
    logic [POS_W-1:0]   vcount_reg,  vcount_next;
    logic               given_reg,   given_next;

    logic [KLEN_W-1:0]  eff_len;
    logic               key_done;
    logic               sep_open;
    logic [CHAR_W-1:0]  key_byte;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   vcount_inc;

    // Key length clamps to the key register size
    assign eff_len  = (key.length > KLEN_W'(KEY_MAX)) ? KLEN_W'(KEY_MAX) : key.length;
    assign key_done = (match_reg >= eff_len);
    assign key_byte = key.chars[{match_reg[2:0], 3'b000} +: CHAR_W];
    assign sep_open = (c == CH_SEP) && !bsl_reg;

    // Saturating counters
    assign pos_inc    = (pos_reg == POS_CAP)    ? POS_CAP : pos_reg + 1'b1;
    assign vcount_inc = (vcount_reg == POS_CAP) ? POS_CAP : vcount_reg + 1'b1;

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        match_next  = match_reg;
        bsl_next    = bsl_reg;
        pos_next    = pos_reg;
        vstart_next = vstart_reg;
        vcount_next = vcount_reg;
        given_next  = given_reg;
        result      = '0;

        if (step)
        begin
            if (c == CH_NUL)
            begin
                // end of string: report if nothing reported yet, then clear
                if (!given_reg)
                begin
                    result.valid = 1'b1;
                    case (phase_reg)
                        PH_SEP:
                            result.status = (eff_len == '0 && pos_reg != '0)
                                            ? ST_NO_VALUE : ST_NOT_FOUND;
                        PH_MATCH:
                            result.status = key_done ? ST_NO_VALUE : ST_NOT_FOUND;
                        PH_VALSTART:
                        begin
                            result.status = ST_VALUE;
                            result.offset = pos_reg;
                        end
                        PH_VALUE:
                        begin
                            result.status = ST_VALUE;
                            result.offset = vstart_reg;
                            result.length = vcount_reg;
                        end
                        default:
                            result.status = ST_NOT_FOUND;
                    endcase
                end
                phase_next  = PH_SEP;
                match_next  = '0;
                bsl_next    = 1'b0;
                pos_next    = '0;
                vstart_next = '0;
                vcount_next = '0;
                given_next  = 1'b0;
            end
            else
            begin
                if (!given_reg)
                begin
                    case (phase_reg)
                        PH_SEP, PH_MATCH:
                        begin
                            // separator runs at field start are skipped
                            if (!(phase_reg == PH_SEP && c == CH_SEP))
                            begin
                                if (!key_done)
                                begin
                                    if (c == key_byte)
                                    begin
                                        match_next = match_reg + 1'b1;
                                        phase_next = PH_MATCH;
                                    end
                                    else if (sep_open)
                                    begin
                                        phase_next = PH_SEP;
                                        match_next = '0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                                else if (c == CH_EQ)
                                begin
                                    phase_next = PH_VALSTART;
                                end
                                else if (c == CH_SEP)
                                begin
                                    result.valid  = 1'b1;
                                    result.status = ST_NO_VALUE;
                                    given_next    = 1'b1;
                                end
                                else if (sep_open)
                                begin
                                    phase_next = PH_SEP;
                                    match_next = '0;
                                end
                                else
                                begin
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        PH_VALSTART:
                        begin
                            // "=;" counts as no value
                            if (c == CH_SEP)
                            begin
                                result.valid  = 1'b1;
                                result.status = ST_NO_VALUE;
                                given_next    = 1'b1;
                            end
                            else
                            begin
                                vstart_next = pos_reg;
                                vcount_next = POS_W'(1);
                                phase_next  = PH_VALUE;
                            end
                        end
                        PH_VALUE:
                        begin
                            if (sep_open)
                            begin
                                result.valid  = 1'b1;
                                result.status = ST_VALUE;
                                result.offset = vstart_reg;
                                result.length = vcount_reg;
                                given_next    = 1'b1;
                            end
                            else
                            begin
                                vcount_next = vcount_inc;
                            end
                        end
                        default:
                        begin
                            // rest of a non-matching field
                            if (sep_open)
                            begin
                                phase_next = PH_SEP;
                                match_next = '0;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    endcase
                end
                bsl_next = (c == CH_BSL);
                pos_next = pos_inc;
            end
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEP;
            match_reg  <= '0;
            bsl_reg    <= 1'b0;
            pos_reg    <= '0;
            vstart_reg <= '0;
            vcount_reg <= '0;
            given_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            match_reg  <= match_next;
            bsl_reg    <= bsl_next;
            pos_reg    <= pos_next;
            vstart_reg <= vstart_next;
            vcount_reg <= vcount_next;
            given_reg  <= given_next;
        end
    end

endmodule

// ===== design/attribute_key_value_finder.sv =====
// Channel     Dir   Payload                                   Transfer
// char_ch     in    char_in[7:0]                              valid && ready
// result_ch   out   status[1:0], value_offset, value_length   valid && ready
// cfg_ch      in    index[0], data[63:0]                      valid && ready
//
// One byte per cycle while result_ch is not stalled: an input register feeds the
// scanner, whose result is registered in an output register.
// A byte's result (if any) reaches result_ch through the input and output registers.
// Reset (rst_n low, async) clears key to length 1 / all zero and the scan state.
// A result waiting on result_ch holds the byte register; bytes keep flowing
// while the output register is empty or being drained.
module attribute_key_value_finder
    import akv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    akv_char_if.sink      char_ch,
    akv_result_if.source  result_ch,
    akv_cfg_if.sink       cfg_ch
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              res_valid_reg;
    akv_result_t       res_reg;
    logic              slot_free;
    logic              step;
    akv_key_t          key;
    akv_result_t       scan_res;

    // Handshake control
    assign slot_free     = !res_valid_reg || result_ch.ready;
    assign step          = in_valid_reg && slot_free;
    assign char_ch.ready = !in_valid_reg || slot_free;

    akv_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .key   (key)
    );

    akv_scanner u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .c      (char_reg),
        .key    (key),
        .result (scan_res)
    );

    // Input byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_ch.ready)
            in_valid_reg <= char_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready)
            char_reg <= char_ch.char_in;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (slot_free)
            res_valid_reg <= step && scan_res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && scan_res.valid)
            res_reg <= scan_res;
    end

    assign result_ch.valid        = res_valid_reg;
    assign result_ch.status       = res_reg.status;
    assign result_ch.value_offset = res_reg.offset;
    assign result_ch.value_length = res_reg.length;

endmodule

// ===== design/akv_checker.sv =====
module akv_checker
    import akv_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                char_valid,
    input logic                char_ready,
    input logic                res_valid,
    input logic                res_ready,
    input logic [STATUS_W-1:0] status,
    input logic [POS_W-1:0]    value_offset,
    input logic [POS_W-1:0]    value_length
);

    // A stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status)
            && $stable(value_offset) && $stable(value_length))
        else $error("result changed while stalled");

    // Only defined status codes, and offset/length only with a value
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (status == ST_NOT_FOUND || status == ST_NO_VALUE
            || status == ST_VALUE))
        else $error("bad status code");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_VALUE |-> value_offset == '0 && value_length == '0)
        else $error("offset or length set without a value");

    // A fresh result follows an earlier byte transfer
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(char_valid && char_ready, 2))
        else $error("result without a byte");

    // Bytes are taken whenever the output register is empty
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> char_ready)
        else $error("input stalled with empty output");

endmodule

bind attribute_key_value_finder akv_checker u_akv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_valid   (char_ch.valid),
    .char_ready   (char_ch.ready),
    .res_valid    (result_ch.valid),
    .res_ready    (result_ch.ready),
    .status       (result_ch.status),
    .value_offset (result_ch.value_offset),
    .value_length (result_ch.value_length)
);
